// File: sv/assert_macros.svh
// Assertion macros shared by the RTL files.
// Each macro samples on the rising edge of aclk and is switched off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_IMPL(label, !(cond), msg)

`endif

// File: sv/cmat_pkg.sv
package cmat_pkg;

    localparam int PRICE_W     = 32;
    localparam int CHAN_IN_W   = 4;
    localparam int COUNT_OUT_W = 3;
    localparam int TREND_W     = 2;
    localparam int DIV_STEPS   = 4;

    localparam logic [TREND_W-1:0] TREND_NONE = 2'd0;
    localparam logic [TREND_W-1:0] TREND_RISE = 2'd1;
    localparam logic [TREND_W-1:0] TREND_FALL = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_STATE,
        ST_READ_WINDOW,
        ST_DIVIDE,
        ST_COMMIT
    } cmat_state_t;

endpackage

// File: sv/channel_moving_average_trend_unit.sv
// Per-channel five-sample moving average with price and mean trend marks.
// Input channel (s_valid/s_ready): one request carries a channel number and
// an unsigned Q16.16 price. Result channel (m_valid/m_ready): one request per
// input with the channel, the truncated window mean, the newest price, the
// two trend marks and the number of samples now held.
// Samples are handled one at a time: a new request is taken only once the
// last one is through. Each request reads the channel state, then, once
// the channel's window is full, the oldest sample from the window memory,
// then runs the divider, which produces four quotient bits per cycle over the
// 35-bit running sum, and then commits the result to the output register.
// Per-channel state lives in a small memory whose entries read as zero until
// first written, so reset takes effect at once with no clearing pass.
// The window memory is not cleared; a slot is always written before it is read.
// When the receiver stalls, the result waits in the output register; the
// next input is still accepted and worked on, and it holds in its last step
// until the output register is free.
`include "assert_macros.svh"

module channel_moving_average_trend_unit
    import cmat_pkg::*;
    #(
        parameter int CHANNELS = 16,
        parameter int WINDOW   = 5
    )
    (
        input  logic                   aclk,
        input  logic                   aresetn,
        input  logic                   s_valid,
        output logic                   s_ready,
        input  logic [CHAN_IN_W-1:0]   s_channel,
        input  logic [PRICE_W-1:0]     s_price,
        output logic                   m_valid,
        input  logic                   m_ready,
        output logic [CHAN_IN_W-1:0]   m_channel_echo,
        output logic [PRICE_W-1:0]     m_mean_value,
        output logic [PRICE_W-1:0]     m_latest_value,
        output logic [TREND_W-1:0]     m_value_trend,
        output logic [TREND_W-1:0]     m_mean_trend,
        output logic [COUNT_OUT_W-1:0] m_sample_count
    );

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = PRICE_W + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
    localparam int DEPTH  = CHANNELS * WINDOW;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POS_W  = CNT_W + 1;

    typedef struct packed {
        logic [SLOT_W-1:0]  oldest;
        logic [CNT_W-1:0]   fill;
        logic [SUM_W-1:0]   sum;
        logic [PRICE_W-1:0] prev_value;
        logic [PRICE_W-1:0] prev_mean;
        logic [TREND_W-1:0] value_dir;
        logic [TREND_W-1:0] mean_dir;
    } chan_rec_t;

    localparam int REC_W = $bits(chan_rec_t);

    cmat_state_t state_reg;
    cmat_state_t state_next;

    logic [CH_W-1:0]    ch_reg;
    logic [CH_W-1:0]    ch_next;
    logic [PRICE_W-1:0] price_reg;
    logic [PRICE_W-1:0] price_next;
    logic [SLOT_W-1:0]  old_reg;
    logic [SLOT_W-1:0]  old_next;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [PRICE_W-1:0] pv_reg;
    logic [PRICE_W-1:0] pv_next;
    logic [PRICE_W-1:0] pm_reg;
    logic [PRICE_W-1:0] pm_next;
    logic [TREND_W-1:0] vd_reg;
    logic [TREND_W-1:0] vd_next;
    logic [TREND_W-1:0] md_reg;
    logic [TREND_W-1:0] md_next;
    logic [PRICE_W-1:0] mean_reg;
    logic [PRICE_W-1:0] mean_next;

    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [CHAN_IN_W-1:0]   o_chan_reg;
    logic [PRICE_W-1:0]     o_mean_reg;
    logic [PRICE_W-1:0]     o_price_reg;
    logic [TREND_W-1:0]     o_vtrend_reg;
    logic [TREND_W-1:0]     o_mtrend_reg;
    logic [COUNT_OUT_W-1:0] o_count_reg;

    logic [CH_W-1:0]    ch_in;
    logic [REC_W-1:0]   rec_rdata;
    logic [REC_W-1:0]   rec_wdata;
    chan_rec_t          rec_rd;
    chan_rec_t          rec_wr;
    logic [SLOT_W-1:0]  old_clamp;
    logic [CNT_W-1:0]   fill_clamp;
    logic               window_full;
    logic [POS_W-1:0]   pos_sum;
    logic [POS_W-1:0]   pos;
    logic [ADDR_W-1:0]  base_addr;
    logic [ADDR_W-1:0]  win_addr;
    logic [PRICE_W-1:0] win_rdata;
    logic [SUM_W-1:0]   sum_calc;
    logic [CNT_W-1:0]   fill_calc;
    logic [SLOT_W-1:0]  old_inc;
    logic [PRICE_W-1:0] pv_new;
    logic [PRICE_W-1:0] pm_new;
    logic [TREND_W-1:0] vd_new;
    logic [TREND_W-1:0] md_new;
    logic               out_free;

    logic               accept;
    logic               rec_rd_en;
    logic               rec_we;
    logic               win_rd_en;
    logic               win_we;
    logic               div_start;
    logic [CNT_W-1:0]   div_divisor;
    logic               div_done;
    logic [PRICE_W-1:0] div_quotient;
    logic               out_load;

    // Channel numbers beyond the configured count wrap around.
    always_comb begin
        ch_in = '0;
        for (int i = 0; i < (1 << CHAN_IN_W); i++) begin
            if (s_channel == CHAN_IN_W'(i)) begin
                ch_in = CH_W'(i % CHANNELS);
            end
        end
    end

    assign rec_rd      = chan_rec_t'(rec_rdata);
    assign old_clamp   = ({1'b0, rec_rd.oldest} >= (SLOT_W + 1)'(WINDOW)) ? '0 : rec_rd.oldest;
    assign fill_clamp  = (rec_rd.fill > CNT_W'(WINDOW)) ? CNT_W'(WINDOW) : rec_rd.fill;
    assign window_full = (fill_clamp == CNT_W'(WINDOW));
    assign pos_sum     = POS_W'(old_clamp) + POS_W'(fill_clamp);
    assign pos         = (pos_sum >= POS_W'(WINDOW)) ? pos_sum - POS_W'(WINDOW) : pos_sum;
    assign base_addr   = ADDR_W'(ch_reg * WINDOW);
    assign old_inc     = (old_reg == SLOT_W'(WINDOW - 1)) ? '0 : SLOT_W'(old_reg + 1'b1);
    assign out_free    = !m_valid_reg || m_ready;

    always_comb begin
        win_addr  = base_addr + ADDR_W'(old_reg);
        sum_calc  = sum_reg;
        fill_calc = fill_reg;
        if (state_reg == ST_READ_STATE) begin
            if (window_full) begin
                win_addr  = base_addr + ADDR_W'(old_clamp);
                sum_calc  = rec_rd.sum;
                fill_calc = fill_clamp;
            end else begin
                win_addr  = base_addr + ADDR_W'(pos);
                sum_calc  = rec_rd.sum + SUM_W'(price_reg);
                fill_calc = CNT_W'(fill_clamp + 1'b1);
            end
        end else if (state_reg == ST_READ_WINDOW) begin
            sum_calc = sum_reg - SUM_W'(win_rdata) + SUM_W'(price_reg);
        end
    end

    always_comb begin
        pv_new = pv_reg;
        vd_new = vd_reg;
        pm_new = pm_reg;
        md_new = md_reg;
        if (pv_reg < price_reg) begin
            pv_new = price_reg;
            vd_new = TREND_RISE;
        end else if (pv_reg > price_reg) begin
            pv_new = price_reg;
            vd_new = TREND_FALL;
        end
        if (pm_reg < mean_reg) begin
            pm_new = mean_reg;
            md_new = TREND_RISE;
        end else if (pm_reg > mean_reg) begin
            pm_new = mean_reg;
            md_new = TREND_FALL;
        end
    end

    always_comb begin
        rec_wr.oldest     = old_reg;
        rec_wr.fill       = fill_reg;
        rec_wr.sum        = sum_reg;
        rec_wr.prev_value = pv_new;
        rec_wr.prev_mean  = pm_new;
        rec_wr.value_dir  = vd_new;
        rec_wr.mean_dir   = md_new;
    end

    assign rec_wdata = REC_W'(rec_wr);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_READ_STATE;
                end
            end
            ST_READ_STATE: begin
                state_next = window_full ? ST_READ_WINDOW : ST_DIVIDE;
            end
            ST_READ_WINDOW: begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        rec_rd_en   = 1'b0;
        rec_we      = 1'b0;
        win_rd_en   = 1'b0;
        win_we      = 1'b0;
        div_start   = 1'b0;
        div_divisor = fill_reg;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                rec_rd_en = s_valid;
            end
            ST_READ_STATE: begin
                win_rd_en   = window_full;
                win_we      = !window_full;
                div_start   = !window_full;
                div_divisor = fill_calc;
            end
            ST_READ_WINDOW: begin
                win_we    = 1'b1;
                div_start = 1'b1;
            end
            ST_DIVIDE: begin
            end
            ST_COMMIT: begin
                rec_we   = out_free;
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    assign accept = s_valid && s_ready;

    always_comb begin
        ch_next      = ch_reg;
        price_next   = price_reg;
        old_next     = old_reg;
        fill_next    = fill_reg;
        sum_next     = sum_reg;
        pv_next      = pv_reg;
        pm_next      = pm_reg;
        vd_next      = vd_reg;
        md_next      = md_reg;
        mean_next    = mean_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            ch_next    = ch_in;
            price_next = s_price;
        end
        if (state_reg == ST_READ_STATE) begin
            old_next  = old_clamp;
            fill_next = fill_calc;
            sum_next  = sum_calc;
            pv_next   = rec_rd.prev_value;
            pm_next   = rec_rd.prev_mean;
            vd_next   = rec_rd.value_dir;
            md_next   = rec_rd.mean_dir;
        end
        if (state_reg == ST_READ_WINDOW) begin
            sum_next = sum_calc;
            old_next = old_inc;
        end
        if (div_done) begin
            mean_next = div_quotient;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg    <= ch_next;
        price_reg <= price_next;
        old_reg   <= old_next;
        fill_reg  <= fill_next;
        sum_reg   <= sum_next;
        pv_reg    <= pv_next;
        pm_reg    <= pm_next;
        vd_reg    <= vd_next;
        md_reg    <= md_next;
        mean_reg  <= mean_next;
        if (out_load) begin
            o_chan_reg   <= CHAN_IN_W'(ch_reg);
            o_mean_reg   <= mean_reg;
            o_price_reg  <= price_reg;
            o_vtrend_reg <= vd_new;
            o_mtrend_reg <= md_new;
            o_count_reg  <= COUNT_OUT_W'(fill_reg);
        end
    end

    cmat_state_ram #(
        .DEPTH  (CHANNELS),
        .ADDR_W (CH_W),
        .DATA_W (REC_W)
    ) u_state_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rec_rd_en),
        .rd_addr (ch_in),
        .rd_data (rec_rdata),
        .wr_en   (rec_we),
        .wr_addr (ch_reg),
        .wr_data (rec_wdata)
    );

    cmat_window_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (PRICE_W)
    ) u_window_ram (
        .aclk    (aclk),
        .rd_en   (win_rd_en),
        .wr_en   (win_we),
        .addr    (win_addr),
        .wr_data (price_reg),
        .rd_data (win_rdata)
    );

    cmat_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W),
        .QUOTIENT_W (PRICE_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_calc),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign m_valid        = m_valid_reg;
    assign m_channel_echo = o_chan_reg;
    assign m_mean_value   = o_mean_reg;
    assign m_latest_value = o_price_reg;
    assign m_value_trend  = o_vtrend_reg;
    assign m_mean_trend   = o_mtrend_reg;
    assign m_sample_count = o_count_reg;

    `ASSERT_IMPL(a_accept_reads_state, accept |=> state_reg == ST_READ_STATE,
        "accepted request did not move to the state read")
    `ASSERT_IMPL(a_div_done_in_divide, div_done |-> state_reg == ST_DIVIDE,
        "divider finished outside the divide step")
    `ASSERT_IMPL(a_result_from_commit, $rose(m_valid) |-> $past(state_reg) == ST_COMMIT,
        "result appeared without a commit step")

endmodule

// File: sv/cmat_state_ram.sv
module cmat_state_ram
    #(
        parameter int DEPTH  = 16,
        parameter int ADDR_W = 4,
        parameter int DATA_W = 64
    )
    (
        input  logic              aclk,
        input  logic              aresetn,
        input  logic              rd_en,
        input  logic [ADDR_W-1:0] rd_addr,
        output logic [DATA_W-1:0] rd_data,
        input  logic              wr_en,
        input  logic [ADDR_W-1:0] wr_addr,
        input  logic [DATA_W-1:0] wr_data
    );

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic              rd_valid_reg;
    logic [DATA_W-1:0] rd_data_reg;

    // Entries that were never written read as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: sv/cmat_window_ram.sv
module cmat_window_ram
    #(
        parameter int DEPTH  = 80,
        parameter int ADDR_W = 7,
        parameter int DATA_W = 32
    )
    (
        input  logic              aclk,
        input  logic              rd_en,
        input  logic              wr_en,
        input  logic [ADDR_W-1:0] addr,
        input  logic [DATA_W-1:0] wr_data,
        output logic [DATA_W-1:0] rd_data
    );

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/cmat_div.sv
`include "assert_macros.svh"

module cmat_div
    import cmat_pkg::*;
    #(
        parameter int DIVIDEND_W = 35,
        parameter int DIVISOR_W  = 3,
        parameter int QUOTIENT_W = 32
    )
    (
        input  logic                  aclk,
        input  logic                  aresetn,
        input  logic                  start,
        input  logic [DIVIDEND_W-1:0] dividend,
        input  logic [DIVISOR_W-1:0]  divisor,
        output logic                  done,
        output logic [QUOTIENT_W-1:0] quotient
    );

    localparam int ITERS  = (DIVIDEND_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int PAD_W  = ITERS * DIV_STEPS;
    localparam int ITER_W = $clog2(ITERS + 1);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [ITER_W-1:0]    cnt_reg;
    logic [ITER_W-1:0]    cnt_next;
    logic [PAD_W-1:0]     work_reg;
    logic [PAD_W-1:0]     work_next;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] rem_next;
    logic [DIVISOR_W-1:0] div_reg;
    logic [DIVISOR_W-1:0] div_next;
    logic [PAD_W-1:0]     work_step;
    logic [DIVISOR_W-1:0] rem_step;

    // Restoring division, several quotient bits per cycle. The dividend shifts
    // out of the top of the work register while quotient bits shift in below.
    always_comb begin
        logic [DIVISOR_W:0]   shifted;
        logic [PAD_W-1:0]     w;
        logic [DIVISOR_W-1:0] r;
        w = work_reg;
        r = rem_reg;
        for (int k = 0; k < DIV_STEPS; k++) begin
            shifted = {r, w[PAD_W-1]};
            w = {w[PAD_W-2:0], 1'b0};
            if (shifted >= {1'b0, div_reg}) begin
                shifted = shifted - {1'b0, div_reg};
                w[0] = 1'b1;
            end
            r = shifted[DIVISOR_W-1:0];
        end
        work_step = w;
        rem_step  = r;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = ITER_W'(ITERS);
            work_next = PAD_W'(dividend);
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            work_next = work_step;
            rem_next  = rem_step;
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == ITER_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign done     = done_reg;
    assign quotient = work_reg[QUOTIENT_W-1:0];

    `ASSERT_NEVER(a_div_start_while_busy, start && busy_reg, "divider restarted while busy")
    `ASSERT_IMPL(a_div_done_ends_busy, done_reg |-> !busy_reg, "divider done while still busy")
    `ASSERT_IMPL(a_div_start_nonzero, start |-> divisor != '0, "divider started with zero divisor")

endmodule
